/* src/png_stored_deflate_writer_defines.svh */
// Assertion macros for the PNG stored-deflate writer modules.
`ifndef PNG_STORED_DEFLATE_WRITER_DEFINES_SVH
`define PNG_STORED_DEFLATE_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define PSDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define PSDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PSDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/psdw_pkg.sv */
// Types, constants and CRC table of the PNG stored-deflate writer.
package psdw_pkg;

    // Queue depths
    localparam int CMD_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    // Input item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // Checksum constants
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [31:0] CRC_INIT  = 32'hffff_ffff;

    // Last step of each output sequence
    localparam logic [5:0] START_LAST  = 6'd42;
    localparam logic [5:0] ROWHDR_LAST = 6'd5;
    localparam logic [5:0] END_LAST    = 6'd19;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_ALPHA  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       file_end;
    } t_out_item;

    typedef struct packed {
        logic [13:0] eff_w;
        logic [13:0] eff_h;
        logic        has_alpha;
        logic [15:0] row_len;
    } t_cfg;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_PIX   = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic       row_first;
        logic       final_row;
        logic       img_end;
        logic [7:0] pixel_byte;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_ROWHDR,
        PH_PIX,
        PH_END
    } t_phase;

    typedef enum logic [1:0] {
        CRC_NONE,
        CRC_UPD,
        CRC_RESTART
    } t_crc_op;

    // Reflected CRC-32 nibble table
    function automatic logic [31:0] crc_nib(input logic [3:0] idx);
        logic [31:0] v;
        unique case (idx)
            4'h0: v = 32'h00000000;
            4'h1: v = 32'h1db71064;
            4'h2: v = 32'h3b6e20c8;
            4'h3: v = 32'h26d930ac;
            4'h4: v = 32'h76dc4190;
            4'h5: v = 32'h6b6b51f4;
            4'h6: v = 32'h4db26158;
            4'h7: v = 32'h5005713c;
            4'h8: v = 32'hedb88320;
            4'h9: v = 32'hf00f9344;
            4'ha: v = 32'hd6d6a3e8;
            4'hb: v = 32'hcb61b38c;
            4'hc: v = 32'h9b64c2b0;
            4'hd: v = 32'h86d3d2d4;
            4'he: v = 32'ha00ae278;
            default: v = 32'hbdbdf21c;
        endcase
        return v;
    endfunction

    // Fold one byte into the CRC, one nibble at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        c = {4'd0, c[31:4]} ^ crc_nib(c[3:0]);
        c = {4'd0, c[31:4]} ^ crc_nib(c[3:0]);
        return c;
    endfunction

endpackage

/* src/psdw_fifo.sv */
// Small first-in first-out queue built from registers.
module psdw_fifo
    import psdw_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push_ok, w_pop_ok;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_push_ok, w_pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* src/psdw_front.sv */
// Front end: accepts input items, tracks frame position and queues commands.
module psdw_front
    import psdw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_in_item,
    output logic     o_full,
    input  t_cfg     i_cfg,
    input  logic     i_q_full,
    output logic     o_cmd_push,
    output t_cmd     o_cmd
);

    logic        r_active;
    logic [15:0] r_row_bytes;
    logic [13:0] r_rows;
    logic        n_active;
    logic [15:0] n_row_bytes;
    logic [13:0] n_rows;

    logic        w_accept;
    logic [15:0] w_nb;
    logic [13:0] w_nr;
    logic        w_row_done;
    logic        w_img_done;

    assign o_full     = i_q_full;
    assign w_accept   = i_push && !i_q_full;
    assign w_nb       = r_row_bytes + 16'd1;
    assign w_nr       = r_rows + 14'd1;
    assign w_row_done = (w_nb >= i_cfg.row_len);
    assign w_img_done = w_row_done && (w_nr >= i_cfg.eff_h);

    // Classify the item and update the frame position
    always_comb begin
        n_active         = r_active;
        n_row_bytes      = r_row_bytes;
        n_rows           = r_rows;
        o_cmd_push       = 1'b0;
        o_cmd.kind       = CMD_PIX;
        o_cmd.row_first  = (r_row_bytes == 16'd0);
        o_cmd.final_row  = (w_nr >= i_cfg.eff_h);
        o_cmd.img_end    = w_img_done;
        o_cmd.pixel_byte = i_in_item.pixel_byte;
        if (w_accept) begin
            if (i_in_item.mode == MODE_START) begin
                o_cmd.kind  = CMD_START;
                o_cmd_push  = 1'b1;
                n_active    = 1'b1;
                n_row_bytes = '0;
                n_rows      = '0;
            end else if (r_active) begin
                o_cmd_push  = 1'b1;
                n_row_bytes = w_nb;
                if (w_row_done) begin
                    n_row_bytes = '0;
                    n_rows      = w_nr;
                    if (w_img_done) begin
                        n_active = 1'b0;
                        n_rows   = '0;
                    end
                end
            end
        end
    end

    // Hold frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_row_bytes <= '0;
            r_rows      <= '0;
        end else begin
            r_active    <= n_active;
            r_row_bytes <= n_row_bytes;
            r_rows      <= n_rows;
        end
    end

endmodule

/* src/psdw_back.sv */
// Back end: sequences file bytes per command and keeps the CRC and Adler sums.
`include "png_stored_deflate_writer_defines.svh"
module psdw_back
    import psdw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    input  logic      i_out_full,
    output logic      o_out_push,
    output t_out_item o_out_data
);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_step, n_step;
    t_cmd        r_cmd, n_cmd;
    logic [31:0] r_crc;
    logic [15:0] r_adler_a, r_adler_b;
    logic [31:0] r_idat_len;

    logic        w_fire, w_done, w_load;
    logic [7:0]  w_byte;
    t_crc_op     w_crc_op;
    logic        w_adler;
    logic        w_step_last;
    logic        w_file_end;
    logic        w_run_last;
    logic [31:0] w_ncrc;
    logic [15:0] w_p, w_np;
    logic [16:0] w_blk;
    logic [30:0] w_prod;
    logic [31:0] w_crc_in;
    logic [16:0] w_a_sum, w_a_red, w_b_sum, w_b_red;

    assign w_ncrc = ~r_crc;
    assign w_p    = i_cfg.row_len + 16'd1;
    assign w_np   = ~w_p;

    // IDAT length: 6 + height * (row bytes + 6)
    assign w_blk  = {1'b0, i_cfg.row_len} + 17'd6;
    assign w_prod = {14'd0, w_blk} * {17'd0, i_cfg.eff_h};

    always_ff @(posedge i_clk) begin
        r_idat_len <= {1'b0, w_prod} + 32'd6;
    end

    // Select the byte of the current step and its checksum action
    always_comb begin
        w_byte      = 8'h00;
        w_crc_op    = CRC_NONE;
        w_adler     = 1'b0;
        w_step_last = 1'b0;
        w_file_end  = 1'b0;
        unique case (r_phase)
            PH_START: begin
                unique case (r_step)
                    6'd0:  w_byte = 8'h89;
                    6'd1:  w_byte = 8'h50;
                    6'd2:  w_byte = 8'h4e;
                    6'd3:  w_byte = 8'h47;
                    6'd4:  w_byte = 8'h0d;
                    6'd5:  w_byte = 8'h0a;
                    6'd6:  w_byte = 8'h1a;
                    6'd7:  w_byte = 8'h0a;
                    6'd8, 6'd9, 6'd10: w_byte = 8'h00;
                    6'd11: w_byte = 8'h0d;
                    6'd12: begin w_byte = 8'h49; w_crc_op = CRC_RESTART; end
                    6'd13: begin w_byte = 8'h48; w_crc_op = CRC_UPD; end
                    6'd14: begin w_byte = 8'h44; w_crc_op = CRC_UPD; end
                    6'd15: begin w_byte = 8'h52; w_crc_op = CRC_UPD; end
                    6'd16, 6'd17, 6'd20, 6'd21, 6'd26, 6'd27, 6'd28: begin
                        w_byte   = 8'h00;
                        w_crc_op = CRC_UPD;
                    end
                    6'd18: begin w_byte = {2'b00, i_cfg.eff_w[13:8]}; w_crc_op = CRC_UPD; end
                    6'd19: begin w_byte = i_cfg.eff_w[7:0]; w_crc_op = CRC_UPD; end
                    6'd22: begin w_byte = {2'b00, i_cfg.eff_h[13:8]}; w_crc_op = CRC_UPD; end
                    6'd23: begin w_byte = i_cfg.eff_h[7:0]; w_crc_op = CRC_UPD; end
                    6'd24: begin w_byte = 8'h08; w_crc_op = CRC_UPD; end
                    6'd25: begin
                        w_byte   = i_cfg.has_alpha ? 8'h06 : 8'h02;
                        w_crc_op = CRC_UPD;
                    end
                    6'd29: w_byte = w_ncrc[31:24];
                    6'd30: w_byte = w_ncrc[23:16];
                    6'd31: w_byte = w_ncrc[15:8];
                    6'd32: w_byte = w_ncrc[7:0];
                    6'd33: w_byte = r_idat_len[31:24];
                    6'd34: w_byte = r_idat_len[23:16];
                    6'd35: w_byte = r_idat_len[15:8];
                    6'd36: w_byte = r_idat_len[7:0];
                    6'd37: begin w_byte = 8'h49; w_crc_op = CRC_RESTART; end
                    6'd38: begin w_byte = 8'h44; w_crc_op = CRC_UPD; end
                    6'd39: begin w_byte = 8'h41; w_crc_op = CRC_UPD; end
                    6'd40: begin w_byte = 8'h54; w_crc_op = CRC_UPD; end
                    6'd41: begin w_byte = 8'h78; w_crc_op = CRC_UPD; end
                    6'd42: begin
                        w_byte      = 8'h01;
                        w_crc_op    = CRC_UPD;
                        w_step_last = 1'b1;
                    end
                    default: w_byte = 8'h00;
                endcase
            end
            PH_ROWHDR: begin
                w_crc_op = CRC_UPD;
                unique case (r_step)
                    6'd0: w_byte = {7'd0, r_cmd.final_row};
                    6'd1: w_byte = w_p[7:0];
                    6'd2: w_byte = w_p[15:8];
                    6'd3: w_byte = w_np[7:0];
                    6'd4: w_byte = w_np[15:8];
                    default: begin
                        w_byte      = 8'h00;
                        w_adler     = 1'b1;
                        w_step_last = 1'b1;
                    end
                endcase
            end
            PH_PIX: begin
                w_byte      = r_cmd.pixel_byte;
                w_crc_op    = CRC_UPD;
                w_adler     = 1'b1;
                w_step_last = 1'b1;
            end
            PH_END: begin
                unique case (r_step)
                    6'd0:  begin w_byte = r_adler_b[15:8]; w_crc_op = CRC_UPD; end
                    6'd1:  begin w_byte = r_adler_b[7:0];  w_crc_op = CRC_UPD; end
                    6'd2:  begin w_byte = r_adler_a[15:8]; w_crc_op = CRC_UPD; end
                    6'd3:  begin w_byte = r_adler_a[7:0];  w_crc_op = CRC_UPD; end
                    6'd4,  6'd16: w_byte = w_ncrc[31:24];
                    6'd5,  6'd17: w_byte = w_ncrc[23:16];
                    6'd6,  6'd18: w_byte = w_ncrc[15:8];
                    6'd7:  w_byte = w_ncrc[7:0];
                    6'd8, 6'd9, 6'd10, 6'd11: w_byte = 8'h00;
                    6'd12: begin w_byte = 8'h49; w_crc_op = CRC_RESTART; end
                    6'd13: begin w_byte = 8'h45; w_crc_op = CRC_UPD; end
                    6'd14: begin w_byte = 8'h4e; w_crc_op = CRC_UPD; end
                    6'd15: begin w_byte = 8'h44; w_crc_op = CRC_UPD; end
                    6'd19: begin
                        w_byte      = w_ncrc[7:0];
                        w_file_end  = 1'b1;
                        w_step_last = 1'b1;
                    end
                    default: w_byte = 8'h00;
                endcase
            end
            default: w_byte = 8'h00;
        endcase
    end

    // Mark the last byte of each command
    assign w_run_last = w_step_last && (r_phase != PH_ROWHDR)
                        && !((r_phase == PH_PIX) && r_cmd.img_end);
    assign w_fire = (r_phase != PH_IDLE) && !i_out_full;
    assign w_done = w_fire && w_run_last;
    assign w_load = ((r_phase == PH_IDLE) || w_done) && !i_cmd_empty;

    // Next sequencer state
    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_cmd   = r_cmd;
        priority if (w_load) begin
            n_cmd  = i_cmd;
            n_step = '0;
            if (i_cmd.kind == CMD_START) begin
                n_phase = PH_START;
            end else if (i_cmd.row_first) begin
                n_phase = PH_ROWHDR;
            end else begin
                n_phase = PH_PIX;
            end
        end else if (w_done) begin
            n_phase = PH_IDLE;
        end else if (w_fire && w_step_last) begin
            n_step = '0;
            unique case (r_phase)
                PH_ROWHDR: n_phase = PH_PIX;
                PH_PIX:    n_phase = PH_END;
                default:   n_phase = PH_IDLE;
            endcase
        end else if (w_fire) begin
            n_step = r_step + 6'd1;
        end
    end

    // Drive handshake and result item
    always_comb begin
        o_cmd_pop           = w_load;
        o_out_push          = w_fire;
        o_out_data.out_byte = w_byte;
        o_out_data.run_last = w_run_last;
        o_out_data.file_end = w_file_end;
    end

    // Checksum arithmetic
    assign w_crc_in = (w_crc_op == CRC_RESTART) ? CRC_INIT : r_crc;
    assign w_a_sum  = {1'b0, r_adler_a} + {9'd0, w_byte};
    assign w_a_red  = (w_a_sum >= ADLER_MOD) ? w_a_sum - ADLER_MOD : w_a_sum;
    assign w_b_sum  = {1'b0, r_adler_b} + {1'b0, w_a_red[15:0]};
    assign w_b_red  = (w_b_sum >= ADLER_MOD) ? w_b_sum - ADLER_MOD : w_b_sum;

    // Advance sequencer and checksums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_step    <= '0;
            r_crc     <= CRC_INIT;
            r_adler_a <= 16'd1;
            r_adler_b <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            if (w_fire) begin
                if (w_crc_op != CRC_NONE) begin
                    r_crc <= crc_byte(w_crc_in, w_byte);
                end
                if ((r_phase == PH_START) && (r_step == 6'd0)) begin
                    r_adler_a <= 16'd1;
                    r_adler_b <= 16'd0;
                end else if (w_adler) begin
                    r_adler_a <= w_a_red[15:0];
                    r_adler_b <= w_b_red[15:0];
                end
            end
        end
    end

    // Hold the current command
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    `PSDW_ASSERT_IMP(a_push_room, i_clk, i_rst_n, o_out_push, !i_out_full, "push into full output")
    `PSDW_ASSERT_IMP(a_adler_range, i_clk, i_rst_n, 1'b1, ({1'b0, r_adler_a} < ADLER_MOD) && ({1'b0, r_adler_b} < ADLER_MOD), "adler sum out of range")
    `PSDW_ASSERT_IMP(a_rowhdr_cmd, i_clk, i_rst_n, r_phase == PH_ROWHDR, r_cmd.row_first && (r_cmd.kind == CMD_PIX), "row header without row start")
    `PSDW_ASSERT_IMP(a_end_cmd, i_clk, i_rst_n, r_phase == PH_END, r_cmd.img_end && (r_cmd.kind == CMD_PIX), "trailer without image end")
    `PSDW_ASSERT_NXT(a_rowhdr_to_pix, i_clk, i_rst_n, w_fire && (r_phase == PH_ROWHDR) && (r_step == ROWHDR_LAST), r_phase == PH_PIX, "row header not followed by pixel")
    `PSDW_ASSERT_IMP(a_file_end_last, i_clk, i_rst_n, o_out_push && w_file_end, w_run_last && (r_step == END_LAST), "file end not on last byte")

endmodule

/* src/png_stored_deflate_writer.sv */
// Top level of the PNG stored-deflate writer: configuration, queues and both ends.
//
// Push a start item (mode 0) to begin a PNG file, then push the raw R,G,B[,A] bytes
// of the image in row-major order; the file bytes come out of the result queue, one
// byte per clock at most. A start item yields 43 bytes, the first pixel byte of a row
// yields 7, the last pixel byte of the image yields 21 (pixel, Adler word, IDAT CRC,
// IEND), and every other pixel byte yields one. The input side takes one item per
// cycle while the command queue has room; the throughput is set by the output
// sequencer, which produces one byte per cycle while the result queue has room.
// Pixel bytes pushed outside a frame are taken and give no output. Width, height
// and alpha are to be written through the configuration port only while the block
// is idle; the block does not enforce this. A zero width or height counts as one.
module png_stored_deflate_writer
    import psdw_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_item    i_in_item,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [13:0] i_cfg_data
);

    logic [13:0] r_width, r_height;
    logic        r_has_alpha;
    t_cfg        w_cfg;

    logic        w_q_full, w_cmd_push, w_cmd_empty, w_cmd_pop;
    t_cmd        w_cmd_in, w_cmd_out;
    logic [$bits(t_cmd)-1:0] w_cmd_bits;
    logic        w_out_full, w_out_push;
    t_out_item   w_out_data;
    logic [$bits(t_out_item)-1:0] w_out_bits;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 14'd1;
            r_height    <= 14'd1;
            r_has_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_width     <= i_cfg_data;
                CFG_HEIGHT: r_height    <= i_cfg_data;
                CFG_ALPHA:  r_has_alpha <= i_cfg_data[0];
                default:    r_width     <= r_width;
            endcase
        end
    end

    // Derive effective sizes and row length
    always_comb begin
        w_cfg.eff_w     = (r_width == 14'd0) ? 14'd1 : r_width;
        w_cfg.eff_h     = (r_height == 14'd0) ? 14'd1 : r_height;
        w_cfg.has_alpha = r_has_alpha;
        w_cfg.row_len   = r_has_alpha ? {w_cfg.eff_w, 2'b00}
                                      : ({1'b0, w_cfg.eff_w, 1'b0} + {2'b00, w_cfg.eff_w});
    end

    psdw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_item  (i_in_item),
        .o_full     (full),
        .i_cfg      (w_cfg),
        .i_q_full   (w_q_full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    psdw_fifo #(
        .DATA_W ($bits(t_cmd)),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_bits),
        .o_empty (w_cmd_empty)
    );

    assign w_cmd_out = t_cmd'(w_cmd_bits);

    psdw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_out_data  (w_out_data)
    );

    psdw_fifo #(
        .DATA_W ($bits(t_out_item)),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_data),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_bits),
        .o_empty (empty)
    );

    assign o_out_item = t_out_item'(w_out_bits);

endmodule

/* tb/tb_png_stored_deflate_writer.sv */
// Self-checking testbench for the PNG stored-deflate writer with a byte-level stream predictor.
`timescale 1ns / 100ps

module tb_png_stored_deflate_writer
    import psdw_pkg::*;
();

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          STALL_CYCLES   = 400;
    localparam int          ADLER_BASE     = 65521;
    localparam logic [31:0] CRC_POLY       = 32'hedb88320;
    localparam logic [63:0] PNG_SIGNATURE  = 64'h8950_4e47_0d0a_1a0a;
    localparam logic [31:0] TYPE_IHDR      = "IHDR";
    localparam logic [31:0] TYPE_IDAT      = "IDAT";
    localparam logic [31:0] TYPE_IEND      = "IEND";

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    t_in_item    i_in_item;
    logic        full;
    logic        pop;
    logic        empty;
    t_out_item   o_out_item;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [13:0] i_cfg_data;

    png_stored_deflate_writer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in_item  (i_in_item),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shared run control
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        rx_hold_cycles;
    int        fail_count;
    int        quiet_cycles;
    t_out_item png_bytes_due[$];
    t_out_item item_bytes[$];
    t_out_item png_byte_want;

    // Predictor state: register copies and running stream state
    logic [13:0] reg_width;
    logic [13:0] reg_height;
    logic        reg_alpha;
    logic [31:0] crc_run;
    int          adler_lo;
    int          adler_hi;
    logic [15:0] row_pos;
    logic [13:0] row_num;
    logic        frame_open;

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Error report
    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Stream predictor
    function automatic int eff_dim(input logic [13:0] v);
        return (v == 14'd0) ? 1 : int'(v);
    endfunction

    function automatic int row_bytes();
        return eff_dim(reg_width) * (reg_alpha ? 4 : 3);
    endfunction

    function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        t_out_item ob;
        ob.out_byte = b;
        ob.run_last = 1'b0;
        ob.file_end = 1'b0;
        item_bytes.push_back(ob);
    endfunction

    function automatic void emit_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            emit_byte(w[8*k +: 8]);
    endfunction

    function automatic void emit_crc_byte(input logic [7:0] b);
        emit_byte(b);
        crc_run = crc_fold(crc_run, b);
    endfunction

    function automatic void emit_crc_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            emit_crc_byte(w[8*k +: 8]);
    endfunction

    function automatic void emit_adler_byte(input logic [7:0] b);
        emit_crc_byte(b);
        adler_lo = (adler_lo + int'(b)) % ADLER_BASE;
        adler_hi = (adler_hi + adler_lo) % ADLER_BASE;
    endfunction

    function automatic void open_chunk(input logic [31:0] len, input logic [31:0] kind);
        emit_word(len);
        crc_run = CRC_INIT;
        emit_crc_word(kind);
    endfunction

    function automatic void close_chunk();
        emit_word(~crc_run);
    endfunction

    function automatic void emit_file_header();
        longint idat_len;
        int     p;
        p = row_bytes() + 1;
        for (int k = 7; k >= 0; k--)
            emit_byte(PNG_SIGNATURE[8*k +: 8]);
        open_chunk(32'd13, TYPE_IHDR);
        emit_crc_word(32'(eff_dim(reg_width)));
        emit_crc_word(32'(eff_dim(reg_height)));
        emit_crc_byte(8'd8);
        emit_crc_byte(reg_alpha ? 8'd6 : 8'd2);
        emit_crc_byte(8'd0);
        emit_crc_byte(8'd0);
        emit_crc_byte(8'd0);
        close_chunk();
        idat_len = 64'd2 + longint'(eff_dim(reg_height)) * longint'(5 + p) + 64'd4;
        open_chunk(idat_len[31:0], TYPE_IDAT);
        emit_crc_byte(8'h78);
        emit_crc_byte(8'h01);
    endfunction

    function automatic void emit_row_header();
        logic [15:0] p;
        p = 16'(row_bytes() + 1);
        emit_crc_byte((int'(row_num) + 1 >= eff_dim(reg_height)) ? 8'd1 : 8'd0);
        emit_crc_byte(p[7:0]);
        emit_crc_byte(p[15:8]);
        emit_crc_byte(~p[7:0]);
        emit_crc_byte(~p[15:8]);
        emit_adler_byte(8'd0);
    endfunction

    function automatic void emit_trailer();
        t_out_item tail;
        emit_crc_word({adler_hi[15:0], adler_lo[15:0]});
        close_chunk();
        open_chunk(32'd0, TYPE_IEND);
        close_chunk();
        tail = item_bytes.pop_back();
        tail.file_end = 1'b1;
        item_bytes.push_back(tail);
    endfunction

    // Work out the file bytes caused by one accepted item and queue them
    function automatic void predict_item(input t_in_item item);
        t_out_item tail;
        item_bytes.delete();
        if (item.mode == MODE_START) begin
            crc_run    = CRC_INIT;
            adler_lo   = 1;
            adler_hi   = 0;
            row_pos    = 16'd0;
            row_num    = 14'd0;
            frame_open = 1'b1;
            emit_file_header();
        end else if (frame_open) begin
            if (row_pos == 16'd0)
                emit_row_header();
            emit_adler_byte(item.pixel_byte);
            row_pos = row_pos + 16'd1;
            if (int'(row_pos) >= row_bytes()) begin
                row_pos = 16'd0;
                row_num = row_num + 14'd1;
                if (int'(row_num) >= eff_dim(reg_height)) begin
                    emit_trailer();
                    frame_open = 1'b0;
                    row_num    = 14'd0;
                end
            end
        end
        if (item_bytes.size() > 0) begin
            tail = item_bytes.pop_back();
            tail.run_last = 1'b1;
            item_bytes.push_back(tail);
            foreach (item_bytes[k])
                png_bytes_due.push_back(item_bytes[k]);
        end
    endfunction

    // Result checker: compare each transfer against the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (png_bytes_due.size() == 0) begin
                flag_error($sformatf("unexpected byte %02h", o_out_item.out_byte));
            end else begin
                png_byte_want = png_bytes_due.pop_front();
                if (o_out_item.out_byte !== png_byte_want.out_byte)
                    flag_error($sformatf("out_byte got %02h want %02h",
                                         o_out_item.out_byte, png_byte_want.out_byte));
                if (o_out_item.run_last !== png_byte_want.run_last)
                    flag_error($sformatf("run_last got %b want %b on byte %02h",
                                         o_out_item.run_last, png_byte_want.run_last,
                                         png_byte_want.out_byte));
                if (o_out_item.file_end !== png_byte_want.file_end)
                    flag_error($sformatf("file_end got %b want %b on byte %02h",
                                         o_out_item.file_end, png_byte_want.file_end,
                                         png_byte_want.out_byte));
            end
        end
    end

    // Receiver: random pop, or hold off for a counted stretch on request
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                pop <= 1'b0;
                rx_hold_cycles--;
            end else begin
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** png_stored_deflate_writer: FAILED **");
        $finish;
    end

    // Offer one item, wait for its transfer, then predict its bytes
    task automatic send_item(input logic item_mode, input logic [7:0] data);
        t_in_item item;
        item.mode       = item_mode;
        item.pixel_byte = data;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= item;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        predict_item(item);
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every expected byte, then let the pipeline settle
    task automatic drain_outputs();
        push <= 1'b0;
        while (png_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write all three registers once the block is quiet
    task automatic program_regs(input logic [13:0] w, input logic [13:0] h, input logic a);
        drain_outputs();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= w;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= h;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ALPHA;
        i_cfg_data <= {13'd0, a};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        reg_width  = w;
        reg_height = h;
        reg_alpha  = a;
    endtask

    // Reset register values: 1x1 RGB, then a stray byte outside the frame
    task automatic test_reset_defaults();
        send_item(MODE_START, 8'h00);
        send_item(MODE_PIXEL, 8'h00);
        send_item(MODE_PIXEL, 8'hff);
        send_item(MODE_PIXEL, 8'h5a);
        send_item(MODE_PIXEL, 8'hc3);
        drain_outputs();
    endtask

    // Largest sizes in IHDR and LEN, then restart while the frame is open
    task automatic test_size_extremes();
        program_regs(14'h3fff, 14'h3fff, 1'b1);
        send_item(MODE_START, 8'hff);
        send_item(MODE_PIXEL, 8'hff);
        send_item(MODE_START, 8'h00);
        drain_outputs();
    endtask

    // Zero width and height count as one
    task automatic test_zero_sizes();
        program_regs(14'd0, 14'd0, 1'b0);
        send_item(MODE_START, 8'h55);
        send_item(MODE_PIXEL, 8'h80);
        send_item(MODE_PIXEL, 8'h01);
        send_item(MODE_PIXEL, 8'h7f);
        drain_outputs();
    endtask

    // Single RGBA pixel
    task automatic test_rgba_pixel();
        program_regs(14'd1, 14'd1, 1'b1);
        send_item(MODE_START, 8'haa);
        send_item(MODE_PIXEL, 8'h12);
        send_item(MODE_PIXEL, 8'h34);
        send_item(MODE_PIXEL, 8'h56);
        send_item(MODE_PIXEL, 8'h78);
        drain_outputs();
    endtask

    // Shrink the image while a frame is open: row and image end on the next byte
    task automatic test_resize_mid_frame();
        program_regs(14'd2, 14'd2, 1'b0);
        send_item(MODE_START, 8'h0f);
        for (int k = 0; k < 4; k++)
            send_item(MODE_PIXEL, 8'(8'h10 + k));
        program_regs(14'd1, 14'd1, 1'b0);
        send_item(MODE_PIXEL, 8'hee);
        drain_outputs();
    endtask

    // Hold off the receiver while the sender keeps offering, then pause until done
    task automatic test_receiver_stall();
        program_regs(14'd4, 14'd3, 1'b1);
        rx_hold_cycles = STALL_CYCLES;
        send_item(MODE_START, 8'(($urandom)));
        for (int k = 0; k < 48; k++)
            send_item(MODE_PIXEL, 8'(($urandom)));
        drain_outputs();
    endtask

    // Random frames: mostly complete, some cut short, some followed by stray bytes
    task automatic test_random_frames(input int item_budget);
        int          sent;
        int          total;
        int          cut;
        int          extra;
        logic [13:0] w;
        logic [13:0] h;
        logic        a;
        sent = 0;
        while (sent < item_budget) begin
            if ($urandom_range(0, 2) != 0 || sent == 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    w = 14'($urandom_range(86, 120));
                    h = 14'd1;
                    a = 1'b0;
                end else begin
                    w = 14'($urandom_range(0, 6));
                    h = 14'($urandom_range(0, 4));
                    a = 1'($urandom_range(0, 1));
                end
                program_regs(w, h, a);
            end
            send_item(MODE_START, 8'(($urandom)));
            sent++;
            total = row_bytes() * eff_dim(reg_height);
            cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
            // Keep the run within its item budget
            if (cut > item_budget - sent)
                cut = item_budget - sent;
            for (int k = 0; k < cut; k++)
                send_item(MODE_PIXEL, 8'(($urandom)));
            sent += cut;
            if (cut == total && $urandom_range(0, 3) == 0) begin
                extra = $urandom_range(1, 3);
                repeat (extra) send_item(MODE_PIXEL, 8'(($urandom)));
                sent += extra;
            end
        end
    endtask

    // Main sequence
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_in_item      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_WIDTH;
        i_cfg_data     = '0;
        tx_idle_pct    = 17;
        rx_idle_pct    = 76;
        rx_hold_cycles = 0;
        fail_count     = 0;
        reg_width      = 14'd1;
        reg_height     = 14'd1;
        reg_alpha      = 1'b0;
        crc_run        = CRC_INIT;
        adler_lo       = 1;
        adler_hi       = 0;
        row_pos        = 16'd0;
        row_num        = 14'd0;
        frame_open     = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_size_extremes();
        test_zero_sizes();
        test_rgba_pixel();
        test_resize_mid_frame();
        test_random_frames(126);

        tx_idle_pct = 76;
        rx_idle_pct = 17;
        test_random_frames(126);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_receiver_stall();
        test_random_frames(126);

        drain_outputs();
        if (png_bytes_due.size() != 0)
            flag_error($sformatf("%0d expected bytes never came", png_bytes_due.size()));
        if (fail_count == 0)
            $display("** png_stored_deflate_writer: PASSED **");
        else
            $display("** png_stored_deflate_writer: FAILED **");
        $finish;
    end

endmodule
